/* hw/rtl/mcde_pkg.sv */
// ----------------------------------------------------------------------------
// mcde_pkg: shared definitions for the multi-channel input debounce block
// Widths, channel count and the event slot type handed between cells.
// ----------------------------------------------------------------------------
package mcde_pkg;

    // Number of debounced channels and the fixed field widths.
    localparam int CHANNELS = 6;
    localparam int LEVEL_W  = 6;
    localparam int IDX_W    = 3;
    localparam int THRESH_W = 10;

    // Reset value of the assert threshold register.
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(3);

    // One pending event as it travels down the cell chain.
    typedef struct packed {
        logic             valid;
        logic             turned_on;
        logic [IDX_W-1:0] channel_index;
    } mcde_slot_t;

    localparam mcde_slot_t SLOT_EMPTY = '{valid: 1'b0, turned_on: 1'b0, channel_index: '0};

endpackage

/* hw/rtl/mcde_cell.sv */
// ----------------------------------------------------------------------------
// mcde_cell: one debounce channel of the cell chain
// Holds the run counter and asserted flag of its channel, produces its event
// when a tick is loaded, and passes event slots toward the output end.
// ----------------------------------------------------------------------------
module mcde_cell
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [mcde_pkg::IDX_W-1:0]     cell_index,
    input  logic [mcde_pkg::THRESH_W-1:0]  threshold,
    input  logic                           level,
    input  logic                           load,
    input  logic                           shift,
    input  mcde_pkg::mcde_slot_t           slot_in,
    input  logic                           any_in,
    output mcde_pkg::mcde_slot_t           slot_out,
    output logic                           any_out
);

    import mcde_pkg::*;

    logic [THRESH_W-1:0] count_reg;
    logic [THRESH_W-1:0] count_next;
    logic                asserted_reg;
    logic                asserted_next;
    mcde_slot_t          slot_reg;
    mcde_slot_t          slot_next;

    logic [THRESH_W-1:0] count_step;
    logic                event_fire;
    logic                event_on;

    // Debounce update for one tick.
    always_comb
    begin
        count_step = (count_reg < threshold) ? count_reg + THRESH_W'(1) : count_reg;
        event_fire = 1'b0;
        event_on   = 1'b0;
        if (level)
        begin
            if ((count_step >= threshold) && !asserted_reg)
            begin
                event_fire = 1'b1;
                event_on   = 1'b1;
            end
        end
        else
        begin
            event_fire = asserted_reg;
        end
    end

    // Next state and slot handling: a load replaces the slot, otherwise it shifts or holds.
    always_comb
    begin
        count_next    = count_reg;
        asserted_next = asserted_reg;
        slot_next     = slot_reg;
        if (load)
        begin
            count_next    = level ? count_step : '0;
            asserted_next = level ? (asserted_reg | event_fire) : 1'b0;
            slot_next     = '{valid: event_fire, turned_on: event_on, channel_index: cell_index};
        end
        else if (shift)
        begin
            slot_next = slot_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            asserted_reg <= 1'b0;
            slot_reg     <= SLOT_EMPTY;
        end
        else
        begin
            count_reg    <= count_next;
            asserted_reg <= asserted_next;
            slot_reg     <= slot_next;
        end
    end

    // Pending-event summary for this cell and all cells above it.
    assign slot_out = slot_reg;
    assign any_out  = slot_reg.valid | any_in;

endmodule

/* hw/rtl/multi_channel_input_debounce_events.sv */
// ----------------------------------------------------------------------------
// multi_channel_input_debounce_events: six-channel counter debounce with events
// Each tick updates all channels at once; ON/OFF events drain in channel order.
// ----------------------------------------------------------------------------
// Events of a tick are loaded into the cells of their channels, shift down the chain
// to cell 0 and pass through the output register, stalling while m_tready is low.
// A new tick is taken only once no event waits in the cells above cell 0 and cell 0
// is empty or moving its event out; a tick with no event, or only a channel 0 event,
// allows one tick a cycle as long as m_tready stays high.
// Reset clears all counters and flags, empties the chain and sets the threshold to 3.
module multi_channel_input_debounce_events
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration: assert_threshold
    input  logic                          cfg_we,
    input  logic [mcde_pkg::THRESH_W-1:0] cfg_wdata,
    // Tick input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [5:0] input_levels, [7:6] zero
    // Event output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [2:0] channel_index, [3] turned_on
    output logic                          m_tlast    // last_event
);

    import mcde_pkg::*;

    logic [THRESH_W-1:0] threshold_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    mcde_slot_t          out_slot_reg;
    mcde_slot_t          out_slot_next;
    logic                out_last_reg;
    logic                out_last_next;

    mcde_slot_t          slot_chain [CHANNELS+1];
    logic                any_chain  [CHANNELS+1];
    logic [LEVEL_W-1:0]  levels;
    logic                pop;
    logic                shift;
    logic                load;

    assign levels = s_tdata[LEVEL_W-1:0];

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    // Chain control: the head slot moves to the output register when that register is empty or its event is taken.
    assign pop      = slot_chain[0].valid && (!out_valid_reg || m_tready);
    assign shift    = !slot_chain[0].valid || pop;
    assign s_tready = !any_chain[1] && shift;
    assign load     = s_tvalid && s_tready;

    // Top of the chain sees nothing above it.
    assign slot_chain[CHANNELS] = SLOT_EMPTY;
    assign any_chain[CHANNELS]  = 1'b0;

    // Row of channel cells.
    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_cell
        mcde_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (IDX_W'(i)),
            .threshold  (threshold_reg),
            .level      (levels[i]),
            .load       (load),
            .shift      (shift),
            .slot_in    (slot_chain[i+1]),
            .any_in     (any_chain[i+1]),
            .slot_out   (slot_chain[i]),
            .any_out    (any_chain[i])
        );
    end

    // Output register: the popped event is last when no event waits above it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_slot_next  = out_slot_reg;
        out_last_next  = out_last_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_slot_next  = slot_chain[0];
            out_last_next  = !any_chain[1];
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_slot_reg <= out_slot_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_slot_reg.turned_on, out_slot_reg.channel_index};
    assign m_tlast  = out_last_reg;

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for multi_channel_input_debounce_events
// Drives poll ticks on the slave stream and checks every ON/OFF event against
// a per-channel debounce predictor. The bench walks the threshold through
// zero, one, small values and the 10-bit maximum, and varies idling on both
// stream sides, with one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import mcde_pkg::*;

    // Cycles to let the event chain settle before a threshold write or the end.
    localparam int DRAIN_CYCLES  = 12;
    // Cycles without any transaction before the run is declared hung.
    localparam int HANG_LIMIT    = 4000;
    // Length of the receiver hold-off used to back up the block.
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_TICKS   = 80;

    // One expected or observed event.
    typedef struct packed {
        logic [IDX_W-1:0] channel_index;
        logic             turned_on;
        logic             last_event;
    } debounce_event_t;

    // Per-channel debounce predictor with a queue of events still owed by the block.
    class debounce_scoreboard;
        logic [THRESH_W-1:0] threshold;
        logic [THRESH_W-1:0] run_len [CHANNELS];
        bit                  is_on   [CHANNELS];
        debounce_event_t     expected_events [$];
        int                  errors;
        int                  ticks;
        int                  on_events;
        int                  off_events;

        function new();
            threshold = THRESH_RESET;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                run_len[ch] = '0;
                is_on[ch]   = 1'b0;
            end
            errors     = 0;
            ticks      = 0;
            on_events  = 0;
            off_events = 0;
        endfunction

        function void set_threshold(input logic [THRESH_W-1:0] value);
            threshold = value;
        endfunction

        // Advance every channel by one tick and queue the events it causes.
        function void note_tick(input logic [LEVEL_W-1:0] levels);
            debounce_event_t tick_events [$];
            debounce_event_t ev;
            ticks++;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                ev.channel_index = IDX_W'(ch);
                ev.last_event    = 1'b0;
                if (levels[ch])
                begin
                    if (run_len[ch] < threshold)
                        run_len[ch] = run_len[ch] + 1'b1;
                    if (run_len[ch] >= threshold && !is_on[ch])
                    begin
                        is_on[ch]    = 1'b1;
                        ev.turned_on = 1'b1;
                        tick_events.push_back(ev);
                    end
                end
                else
                begin
                    run_len[ch] = '0;
                    if (is_on[ch])
                    begin
                        is_on[ch]    = 1'b0;
                        ev.turned_on = 1'b0;
                        tick_events.push_back(ev);
                    end
                end
            end
            if (tick_events.size() > 0)
                tick_events[tick_events.size()-1].last_event = 1'b1;
            foreach (tick_events[i])
                expected_events.push_back(tick_events[i]);
        endfunction

        // Compare one accepted event with the oldest one owed.
        function void check_event(input debounce_event_t got);
            debounce_event_t want;
            if (expected_events.size() == 0)
            begin
                $error("unexpected event: channel_index %0d turned_on %0d last_event %0d",
                       got.channel_index, got.turned_on, got.last_event);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            if (got.turned_on)
                on_events++;
            else
                off_events++;
            if (got.channel_index !== want.channel_index)
            begin
                $error("channel_index expected %0d actual %0d",
                       want.channel_index, got.channel_index);
                errors++;
            end
            if (got.turned_on !== want.turned_on)
            begin
                $error("turned_on expected %0d actual %0d", want.turned_on, got.turned_on);
                errors++;
            end
            if (got.last_event !== want.last_event)
            begin
                $error("last_event expected %0d actual %0d", want.last_event, got.last_event);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [THRESH_W-1:0] cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [7:0]          m_tdata;
    logic                m_tlast;

    debounce_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int threshold_writes;

    multi_channel_input_debounce_events u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver side: random back-pressure, or a counted hold-off when requested.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Event monitor: every accepted event goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_event('{channel_index: m_tdata[2:0], turned_on: m_tdata[3],
                             last_event: m_tlast});
    end

    // Watchdog: ends the run when no transaction happens for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no transaction for %0d cycles", HANG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Offer one tick, with random idle cycles first, and wait for its transaction.
    task automatic send_tick(input logic [LEVEL_W-1:0] levels);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, levels};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_tick(levels);
    endtask

    // Close a burst of ticks so the slave side goes quiet.
    task automatic end_burst();
        s_tvalid <= 1'b0;
    endtask

    // Write the threshold once all owed events are out and the chain is empty.
    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        while (sb.expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_threshold(value);
        threshold_writes++;
    endtask

    // Main stimulus.
    initial
    begin
        logic [LEVEL_W-1:0]  levels;
        logic [THRESH_W-1:0] phase_threshold [RANDOM_PHASES];
        int                  pick;

        phase_threshold  = '{10'd2, 10'd4, 10'd0, 10'd7, 10'd1, 10'd3};
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        hold_left        = 0;
        threshold_writes = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset threshold of three: all channels on together, then all off.
        repeat (3) send_tick(6'h3F);
        send_tick(6'h00);
        // Alternate channels; the complementary pattern turns the first set off.
        repeat (3) send_tick(6'h15);
        send_tick(6'h2A);
        end_burst();

        // Threshold zero behaves like one: on at the first high tick.
        write_threshold(10'd0);
        send_tick(6'h01);
        send_tick(6'h3F);
        send_tick(6'h00);
        end_burst();

        // Maximum threshold, then lowered below the running counts:
        // every channel turns on at the next high tick without counting on.
        write_threshold(10'd1023);
        repeat (5) send_tick(6'h3F);
        end_burst();
        write_threshold(10'd2);
        send_tick(6'h3F);
        send_tick(6'h3F);
        send_tick(6'h00);
        end_burst();

        // Threshold one: a single event, then a mixed tick with ON and OFF events.
        write_threshold(10'd1);
        send_tick(6'h20);
        send_tick(6'h1F);
        send_tick(6'h00);
        end_burst();

        // Random phases: mostly persistent levels so channels build real runs.
        levels = '0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_threshold(phase_threshold[phase]);
            if (phase < 2)
            begin
                send_idle_pct = 36;
                recv_idle_pct = 72;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 36;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // With threshold one, stall the receiver while ticks alternating all high and all low keep coming.
            if (phase == 4)
            begin
                hold_left = HOLD_CYCLES;
                for (int i = 0; i < 24; i++)
                    send_tick((i % 2 == 0) ? 6'h3F : 6'h00);
                levels = '0;
            end

            for (int i = (phase == 4) ? 24 : 0; i < PHASE_TICKS; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                    levels = LEVEL_W'($urandom);
                else if (pick < 11)
                    levels = '0;
                else if (pick < 14)
                    levels = '1;
                else
                begin
                    for (int ch = 0; ch < LEVEL_W; ch++)
                        if ($urandom_range(99) < 15)
                            levels[ch] = ~levels[ch];
                end
                send_tick(levels);
            end
            end_burst();
        end

        // Let every owed event drain, then give the chain time to stay quiet.
        while (sb.expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d ticks and %0d events (%0d on, %0d off) across %0d threshold",
                 sb.ticks, sb.on_events + sb.off_events, sb.on_events, sb.off_events,
                 threshold_writes);
        $display("writes from 0 to 1023, with both stream sides idling and a long hold-off.");
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/mcde_pkg.sv
hw/rtl/mcde_cell.sv
hw/rtl/multi_channel_input_debounce_events.sv
verif/testbench.sv
